>>> design/grid_line_of_sight_query_defines.svh
// Assertion helpers for the block's top-level module.
`ifndef GRID_LINE_OF_SIGHT_QUERY_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_QUERY_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define GLOSQ_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("glosq check failed");

// Check that a trigger is followed by a consequence in the next cycle.
`define GLOSQ_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("glosq sequence check failed");

`endif

>>> design/glosq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package glosq_pkg;
	localparam int CW = 6;
	localparam int XW = 12;
	localparam int FW = 13;
	localparam int PW = 2 * FW;
	localparam int MAX_CELLS = 1 << CW;
	localparam int IT_W = 10;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef logic signed [XW-1:0] coord_t;
	typedef logic signed [FW-1:0] form_t;
	typedef logic signed [PW-1:0] prod_t;

	typedef struct packed {
		coord_t a;
		coord_t b;
	} pair_t;

	typedef struct packed {
		logic en;
		coord_t x;
		coord_t y;
	} rd_req_t;

	typedef struct packed {
		logic en;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic data;
	} wr_req_t;

	typedef struct packed {
		logic gt;
		logic eq;
		logic lt;
	} cmp_res_t;
endpackage
`default_nettype wire

>>> design/glosq_map.sv
`timescale 1ns / 1ps
`default_nettype none
module glosq_map #(
	parameter int MAP_WIDTH = 64,
	parameter int MAP_HEIGHT = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  glosq_pkg::wr_req_t wr,
	input  glosq_pkg::rd_req_t rd,
	output logic               rd_data,
	output logic               busy
);
	import glosq_pkg::*;

	localparam int COLS = (MAP_WIDTH < MAX_CELLS) ? MAP_WIDTH : MAX_CELLS;
	localparam int ROWS = (MAP_HEIGHT < MAX_CELLS) ? MAP_HEIGHT : MAX_CELLS;
	localparam int ROW_W = $clog2(ROWS);
	localparam int AW = ROW_W + CW;
	localparam int DEPTH = ROWS * MAX_CELLS;

	logic mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic clr_busy_q;
	logic rd_bit_q;
	logic rd_ok_q;
	logic wr_hit;
	logic rd_in_map;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign wr_hit = wr.en && ({1'b0, wr.x} < (CW+1)'(COLS)) && ({1'b0, wr.y} < (CW+1)'(ROWS));
	assign wr_addr = {wr.y[ROW_W-1:0], wr.x};
	assign rd_in_map = (rd.x >= 0) && (rd.x < coord_t'(COLS)) &&
		(rd.y >= 0) && (rd.y < coord_t'(ROWS));
	assign rd_addr = {rd.y[ROW_W-1:0], rd.x[CW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= 1'b0;
		end else if (wr_hit) begin
			mem[wr_addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_bit_q <= rd_in_map ? mem[rd_addr] : 1'b0;
			rd_ok_q <= rd_in_map;
		end
	end

	assign rd_data = rd_bit_q && rd_ok_q;
	assign busy = clr_busy_q;
endmodule
`default_nettype wire

>>> design/glosq_xcmp.sv
`timescale 1ns / 1ps
`default_nettype none
module glosq_xcmp (
	input  glosq_pkg::pair_t    d,
	input  glosq_pkg::pair_t    s,
	input  logic                d_plus,
	output glosq_pkg::cmp_res_t res
);
	import glosq_pkg::*;

	form_t off;
	form_t da;
	form_t db;
	form_t sa;
	form_t sb;
	prod_t l;
	prod_t r;

	// compare (2d.a+off)(2s.b-1) against (2d.b+off)(2s.a-1)
	always_comb begin
		off = d_plus ? form_t'(1) : form_t'(-1);
		da = form_t'(d.a) * form_t'(2) + off;
		db = form_t'(d.b) * form_t'(2) + off;
		sa = form_t'(s.a) * form_t'(2) - form_t'(1);
		sb = form_t'(s.b) * form_t'(2) - form_t'(1);
		l = prod_t'(da) * prod_t'(sb);
		r = prod_t'(db) * prod_t'(sa);
		res.gt = l > r;
		res.eq = l == r;
		res.lt = l < r;
	end
endmodule
`default_nettype wire

>>> design/grid_line_of_sight_query.sv
// Writes: ready again the cycle after acceptance, no result.
// Queries: straight lines read each cell between start and end in turn;
// other lines run the octant walk (S_STEP, S_RD1, at times S_CMP1 to S_RD2) through one
// shared cross-product comparator and one map read port, up to 4*(|dx|+|dy|)+16 steps.
// One request at a time; a finished result waits in the output register.
// After reset all min(MAP_HEIGHT,64)*64 map cells are cleared to opaque.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_line_of_sight_query_defines.svh"
module grid_line_of_sight_query #(
	parameter int MAP_WIDTH = 64,
	parameter int MAP_HEIGHT = 64
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// cell_x, cell_y, see_through, start_x, start_y, end_x, end_y
	input  wire [glosq_pkg::S_TDATA_W-1:0]       s_tdata,
	// command
	input  wire                                  s_tuser,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// visible
	output logic [glosq_pkg::M_TDATA_W-1:0]      m_tdata
);
	import glosq_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SETUP   = 4'd1;
	localparam logic [3:0] S_LINE    = 4'd2;
	localparam logic [3:0] S_LINE_RD = 4'd3;
	localparam logic [3:0] S_STEP    = 4'd4;
	localparam logic [3:0] S_RD1     = 4'd5;
	localparam logic [3:0] S_CMP1    = 4'd6;
	localparam logic [3:0] S_CMP2    = 4'd7;
	localparam logic [3:0] S_RD2     = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	logic [3:0] state_q;
	logic [CW-1:0] qsx_q, qsy_q, qex_q, qey_q;
	logic sx_q, sy_q, swap_q, up_q, res_q;
	coord_t ex_q, ey_q, pos_x_q, pos_y_q, stx_q, sty_q;
	pair_t shi_q, slo_q, chi_q, clo_q, n_q;
	logic [IT_W-1:0] it_q, limit_q;
	logic m_tvalid_q;
	logic visible_q;

	logic accept;
	wr_req_t wr;
	rd_req_t rd;
	logic rd_data;
	logic map_busy;
	pair_t cmp_d, cmp_s;
	logic cmp_plus;
	cmp_res_t cmp;

	logic signed [CW:0] dx, dy;
	logic [CW-1:0] ax, ay;
	logic up;
	pair_t step_n;
	pair_t cur_new;
	pair_t oct_src;
	coord_t ou, ov, ox, oy;
	pair_t bound;

	assign s_tready = (state_q == S_IDLE) && !map_busy;
	assign accept = s_tvalid && s_tready;
	assign wr.en = accept && (s_tuser == CMD_WRITE);
	assign wr.x = s_tdata[5:0];
	assign wr.y = s_tdata[11:6];
	assign wr.data = s_tdata[12];

	assign dx = $signed({1'b0, qex_q}) - $signed({1'b0, qsx_q});
	assign dy = $signed({1'b0, qey_q}) - $signed({1'b0, qsy_q});
	assign ax = dx[CW] ? CW'(-dx) : dx[CW-1:0];
	assign ay = dy[CW] ? CW'(-dy) : dy[CW-1:0];

	assign up = chi_q.a <= clo_q.a;
	assign bound.a = up_q ? ex_q : ex_q + coord_t'(1);
	assign bound.b = up_q ? ey_q + coord_t'(1) : ey_q;

	always_comb begin
		cmp_plus = 1'b0;
		cmp_d = slo_q;
		cmp_s = shi_q;
		if (state_q == S_STEP) begin
			cmp_plus = 1'b1;
			cmp_d = up ? chi_q : clo_q;
			cmp_s = up ? shi_q : slo_q;
		end else if (state_q == S_CMP1) begin
			cmp_d = bound;
			cmp_s = up_q ? shi_q : slo_q;
		end
	end

	glosq_xcmp u_xcmp (
		.d      (cmp_d),
		.s      (cmp_s),
		.d_plus (cmp_plus),
		.res    (cmp)
	);

	assign step_n.a = cmp_d.a + ((cmp.lt || cmp.eq) ? coord_t'(1) : coord_t'(0));
	assign step_n.b = cmp_d.b + ((cmp.gt || cmp.eq) ? coord_t'(1) : coord_t'(0));
	assign cur_new.a = n_q.a;
	assign cur_new.b = up_q ? n_q.b + coord_t'(1) : n_q.b - coord_t'(1);

	always_comb begin
		oct_src = (state_q == S_STEP) ? step_n : cur_new;
		ou = swap_q ? oct_src.b : oct_src.a;
		ov = swap_q ? oct_src.a : oct_src.b;
		ox = coord_t'({{(XW-CW){1'b0}}, qsx_q}) + (sx_q ? -ou : ou);
		oy = coord_t'({{(XW-CW){1'b0}}, qsy_q}) + (sy_q ? -ov : ov);
		rd.en = 1'b0;
		rd.x = ox;
		rd.y = oy;
		if (state_q == S_LINE) begin
			rd.x = pos_x_q;
			rd.y = pos_y_q;
			rd.en = !((pos_x_q == coord_t'({{(XW-CW){1'b0}}, qex_q}) &&
				pos_y_q == coord_t'({{(XW-CW){1'b0}}, qey_q})) ||
				(stx_q == 0 && sty_q == 0));
		end else if (state_q == S_STEP) begin
			rd.en = (it_q < limit_q) && !(step_n.a >= ex_q && step_n.b >= ey_q);
		end else if (state_q == S_CMP2) begin
			rd.en = !cmp.gt && !(cur_new.a == ex_q && cur_new.b == ey_q);
		end
	end

	glosq_map #(
		.MAP_WIDTH  (MAP_WIDTH),
		.MAP_HEIGHT (MAP_HEIGHT)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data),
		.busy    (map_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && s_tuser == CMD_QUERY) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					if (dx == 0 || dy == 0 || ax == ay) begin
						state_q <= S_LINE;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_LINE: begin
					state_q <= rd.en ? S_LINE_RD : S_DONE;
				end
				S_LINE_RD: begin
					state_q <= rd_data ? S_LINE : S_DONE;
				end
				S_STEP: begin
					state_q <= rd.en ? S_RD1 : S_DONE;
				end
				S_RD1: begin
					state_q <= rd_data ? S_STEP : S_CMP1;
				end
				S_CMP1: begin
					state_q <= cmp.eq ? S_DONE : S_CMP2;
				end
				S_CMP2: begin
					state_q <= rd.en ? S_RD2 : S_DONE;
				end
				S_RD2: begin
					state_q <= rd_data ? S_STEP : S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				qsx_q <= s_tdata[18:13];
				qsy_q <= s_tdata[24:19];
				qex_q <= s_tdata[30:25];
				qey_q <= s_tdata[36:31];
			end
			S_SETUP: begin
				stx_q <= (dx == 0) ? coord_t'(0) : (dx[CW] ? coord_t'(-1) : coord_t'(1));
				sty_q <= (dy == 0) ? coord_t'(0) : (dy[CW] ? coord_t'(-1) : coord_t'(1));
				pos_x_q <= coord_t'({{(XW-CW){1'b0}}, qsx_q}) +
					((dx == 0) ? coord_t'(0) : (dx[CW] ? coord_t'(-1) : coord_t'(1)));
				pos_y_q <= coord_t'({{(XW-CW){1'b0}}, qsy_q}) +
					((dy == 0) ? coord_t'(0) : (dy[CW] ? coord_t'(-1) : coord_t'(1)));
				sx_q <= dx[CW];
				sy_q <= dy[CW];
				swap_q <= ay > ax;
				ex_q <= coord_t'({{(XW-CW){1'b0}}, (ay > ax) ? ay : ax});
				ey_q <= coord_t'({{(XW-CW){1'b0}}, (ay > ax) ? ax : ay});
				shi_q.a <= coord_t'({{(XW-CW){1'b0}}, (ay > ax) ? ay : ax}) + coord_t'(1);
				shi_q.b <= coord_t'({{(XW-CW){1'b0}}, (ay > ax) ? ax : ay});
				slo_q.a <= coord_t'({{(XW-CW){1'b0}}, (ay > ax) ? ay : ax});
				slo_q.b <= coord_t'({{(XW-CW){1'b0}}, (ay > ax) ? ax : ay}) + coord_t'(1);
				chi_q <= '0;
				clo_q <= '0;
				it_q <= '0;
				limit_q <= {(IT_W-2)'({1'b0, ax} + {1'b0, ay}), 2'b00} + IT_W'(16);
				res_q <= 1'b1;
			end
			S_LINE: begin
				res_q <= 1'b1;
			end
			S_LINE_RD: begin
				pos_x_q <= pos_x_q + stx_q;
				pos_y_q <= pos_y_q + sty_q;
				res_q <= rd_data;
			end
			S_STEP: begin
				n_q <= step_n;
				up_q <= up;
				res_q <= (it_q < limit_q);
			end
			S_RD1: begin
				if (rd_data) begin
					if (up_q) begin
						chi_q <= n_q;
					end else begin
						clo_q <= n_q;
					end
					it_q <= it_q + 1'b1;
				end else if (up_q) begin
					shi_q.a <= n_q.a;
					shi_q.b <= n_q.b + coord_t'(1);
				end else begin
					slo_q.a <= n_q.a + coord_t'(1);
					slo_q.b <= n_q.b;
				end
			end
			S_CMP1: begin
				res_q <= 1'b0;
			end
			S_CMP2: begin
				if (up_q) begin
					chi_q <= cur_new;
				end else begin
					clo_q <= cur_new;
				end
				res_q <= !cmp.gt;
			end
			S_RD2: begin
				it_q <= it_q + 1'b1;
				res_q <= 1'b0;
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					visible_q <= res_q;
				end
			end
			default: begin
				res_q <= 1'b0;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(M_TDATA_W-1){1'b0}}, visible_q};

	`GLOSQ_ASSERT(a_no_accept_clearing, !(map_busy && s_tready))
	`GLOSQ_ASSERT(a_ready_only_idle, !s_tready || state_q == S_IDLE)
	`GLOSQ_ASSERT(a_walk_bounded, state_q != S_STEP || it_q <= limit_q)
	`GLOSQ_ASSERT_NEXT(a_result_issued, state_q == S_DONE && (!m_tvalid_q || m_tready), m_tvalid_q && state_q == S_IDLE)
endmodule
`default_nettype wire
